[design/lru_victim_selector_with_reservation_top_defines.svh]
// ----------------------------------------------------------------------------
// LRU victim selector assertion macros
// Shared property forms for the checks in the selector top module.
// ----------------------------------------------------------------------------
`ifndef LRU_VICTIM_SELECTOR_WITH_RESERVATION_TOP_DEFINES_SVH
`define LRU_VICTIM_SELECTOR_WITH_RESERVATION_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LRUV_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lruv check failed");

// next-cycle implication, checked out of reset
`define LRUV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lruv check failed");

`endif

[design/lruv_pkg.sv]
// ----------------------------------------------------------------------------
// LRU victim selector package
// Key width, operation codes, status codes and slot commands.
// ----------------------------------------------------------------------------
package lruv_pkg;

    localparam int KEY_BITS = 32;

    typedef enum logic [2:0] {
        MODE_ACCESS = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_REMOVE = 3'd2,
        MODE_SELECT = 3'd3,
        MODE_COMMIT = 3'd4,
        MODE_CANCEL = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_NO_ROOM   = 3'd2,
        ST_RESERVED  = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        SLOT_NONE  = 2'd0,
        SLOT_FRONT = 2'd1,
        SLOT_PUSH  = 2'd2,
        SLOT_DROP  = 2'd3
    } t_slot_op;

endpackage

[design/lruv_slot.sv]
// ----------------------------------------------------------------------------
// LRU slot cell
// Holds one key with its valid bit and recency rank; compares against the
// broadcast key and applies the broadcast rank update.
// ----------------------------------------------------------------------------
module lruv_slot
    import lruv_pkg::*;
#(
    parameter int RANK_BITS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_slot_op             i_op,
    input  logic                 i_sel,
    input  logic [RANK_BITS-1:0] i_ref_rank,
    input  logic [KEY_BITS-1:0]  i_key,
    output logic                 o_valid,
    output logic                 o_hit,
    output logic [KEY_BITS-1:0]  o_key,
    output logic [RANK_BITS-1:0] o_rank
);

    logic                 r_valid;
    logic [KEY_BITS-1:0]  r_key;
    logic [RANK_BITS-1:0] r_rank;
    logic                 n_valid;
    logic [KEY_BITS-1:0]  n_key;
    logic [RANK_BITS-1:0] n_rank;

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_rank  = r_rank;
        case (i_op)
            SLOT_FRONT: begin
                if (i_sel) begin
                    n_rank = '0;
                end else if (r_valid && (r_rank < i_ref_rank)) begin
                    n_rank = r_rank + RANK_BITS'(1);
                end
            end
            SLOT_PUSH: begin
                if (i_sel) begin
                    n_valid = 1'b1;
                    n_key   = i_key;
                    n_rank  = '0;
                end else if (r_valid) begin
                    n_rank = r_rank + RANK_BITS'(1);
                end
            end
            SLOT_DROP: begin
                if (i_sel) begin
                    n_valid = 1'b0;
                end else if (r_valid && (r_rank > i_ref_rank)) begin
                    n_rank = r_rank - RANK_BITS'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_rank <= n_rank;
    end

    assign o_valid = r_valid;
    assign o_hit   = r_valid && (r_key == i_key);
    assign o_key   = r_key;
    assign o_rank  = r_rank;

endmodule

[design/lru_victim_selector_with_reservation_top.sv]
// Path: the input register holds each transaction, then the result register presents it on the master side.
// Throughput: one transaction per cycle while the master side accepts results; the slot table updates in one pass.
// Recency state is read and written by the single stage between the input
// and result registers, so each item sees all earlier updates.
// Reset: clears slot valid bits, fill count, reservation and both stage
// valids at once; no clearing pass, keys and ranks are left as they are.
// ----------------------------------------------------------------------------
// LRU victim selector with reservation, top level
// Recency-ordered slot table with two-phase victim reservation.
// ----------------------------------------------------------------------------
`include "lru_victim_selector_with_reservation_top_defines.svh"

module lru_victim_selector_with_reservation_top
    import lruv_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // key[31:0], exclude_key[63:32]
    input  logic [3:0]  i_s_tuser,   // mode[2:0], exclude_valid[3]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // victim_key[31:0]
    output logic [3:0]  o_m_tuser    // status[2:0], victim_valid[3]
);

    localparam int IDX_BITS = $clog2(CAPACITY);
    localparam int CNT_BITS = $clog2(CAPACITY + 1);

    logic                r_in_valid;
    t_mode               r_in_mode;
    logic [KEY_BITS-1:0] r_in_key;
    logic                r_in_ex_valid;
    logic [KEY_BITS-1:0] r_in_ex_key;

    logic                r_out_valid;
    t_status             r_out_status;
    logic                r_out_vvalid;
    logic [KEY_BITS-1:0] r_out_vkey;

    logic                r_rsv_valid;
    logic [IDX_BITS-1:0] r_rsv_slot;
    logic [CNT_BITS-1:0] r_count;

    t_status             n_status;
    logic                n_vvalid;
    logic [KEY_BITS-1:0] n_vkey;
    logic                n_rsv_valid;
    logic [IDX_BITS-1:0] n_rsv_slot;
    logic [CNT_BITS-1:0] n_count;

    logic                fire;
    t_slot_op            slot_op;
    t_slot_op            cell_op;
    logic                use_free;
    logic [CAPACITY-1:0] slot_valid;
    logic [CAPACITY-1:0] hit;
    logic [CAPACITY-1:0] free_1h;
    logic [CAPACITY-1:0] sel_vec;
    logic [CAPACITY-1:0] cand_a;
    logic [CAPACITY-1:0] cand_b;
    logic [CAPACITY-1:0] pick;
    logic [IDX_BITS-1:0] slot_rank [CAPACITY];
    logic [KEY_BITS-1:0] slot_key  [CAPACITY];
    logic [IDX_BITS-1:0] s_rank;
    logic [IDX_BITS-1:0] rank_a;
    logic [IDX_BITS-1:0] rank_b;
    logic [KEY_BITS-1:0] key_a;
    logic [KEY_BITS-1:0] pick_key;
    logic [IDX_BITS-1:0] pick_idx;
    logic                found;
    logic                rsv_hit;
    logic                full;
    logic                two_plus;
    logic                ex_hit;

    assign fire       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_mode     <= t_mode'(i_s_tuser[2:0]);
            r_in_ex_valid <= i_s_tuser[3];
            r_in_key      <= i_s_tdata[KEY_BITS-1:0];
            r_in_ex_key   <= i_s_tdata[63:32];
        end
    end

    assign cell_op = fire ? slot_op : SLOT_NONE;
    assign sel_vec = use_free ? free_1h : (slot_op == SLOT_DROP && r_in_mode == MODE_SELECT)
                                          ? '0 : hit;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
        lruv_slot #(
            .RANK_BITS (IDX_BITS)
        ) u_slot (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_op       (cell_op),
            .i_sel      (sel_vec[g]),
            .i_ref_rank (s_rank),
            .i_key      (r_in_key),
            .o_valid    (slot_valid[g]),
            .o_hit      (hit[g]),
            .o_key      (slot_key[g]),
            .o_rank     (slot_rank[g])
        );
    end

    assign found    = |hit;
    assign rsv_hit  = r_rsv_valid && hit[r_rsv_slot];
    assign full     = &slot_valid;
    assign free_1h  = ~slot_valid & (slot_valid + CAPACITY'(1));
    assign two_plus = r_count >= CNT_BITS'(2);
    assign rank_a   = IDX_BITS'(r_count - CNT_BITS'(1));
    assign rank_b   = IDX_BITS'(r_count - CNT_BITS'(2));

    always_comb begin
        s_rank = '0;
        key_a  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            cand_a[i] = slot_valid[i] && (slot_rank[i] == rank_a);
            cand_b[i] = slot_valid[i] && (slot_rank[i] == rank_b) && two_plus;
            s_rank    = s_rank | (slot_rank[i] & {IDX_BITS{hit[i]}});
            key_a     = key_a | (slot_key[i] & {KEY_BITS{cand_a[i]}});
        end
    end

    assign ex_hit = r_in_ex_valid && (|cand_a) && (key_a == r_in_ex_key);
    assign pick   = ex_hit ? cand_b : cand_a;

    always_comb begin
        pick_idx = '0;
        pick_key = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            pick_idx = pick_idx | (IDX_BITS'(i) & {IDX_BITS{pick[i]}});
            pick_key = pick_key | (slot_key[i] & {KEY_BITS{pick[i]}});
        end
    end

    always_comb begin
        n_status    = ST_OK;
        n_vvalid    = 1'b0;
        n_vkey      = '0;
        n_rsv_valid = r_rsv_valid;
        n_rsv_slot  = r_rsv_slot;
        n_count     = r_count;
        slot_op     = SLOT_NONE;
        use_free    = 1'b0;
        case (r_in_mode)
            MODE_ACCESS: begin
                if (found && !rsv_hit) begin
                    slot_op = SLOT_FRONT;
                end
            end
            MODE_INSERT: begin
                if (found) begin
                    if (rsv_hit) begin
                        n_status = ST_INVALID;
                    end else begin
                        slot_op = SLOT_FRONT;
                    end
                end else if (full) begin
                    n_status = ST_NO_ROOM;
                end else begin
                    slot_op  = SLOT_PUSH;
                    use_free = 1'b1;
                    n_count  = r_count + CNT_BITS'(1);
                end
            end
            MODE_REMOVE: begin
                if (found) begin
                    slot_op = SLOT_DROP;
                    n_count = r_count - CNT_BITS'(1);
                    if (rsv_hit) begin
                        n_rsv_valid = 1'b0;
                    end
                end
            end
            MODE_SELECT: begin
                if (r_rsv_valid) begin
                    n_status = ST_RESERVED;
                end else if (!(|pick)) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    n_rsv_valid = 1'b1;
                    n_rsv_slot  = pick_idx;
                    n_vvalid    = 1'b1;
                    n_vkey      = pick_key;
                end
            end
            MODE_COMMIT: begin
                if (rsv_hit) begin
                    slot_op     = SLOT_DROP;
                    n_count     = r_count - CNT_BITS'(1);
                    n_rsv_valid = 1'b0;
                end else begin
                    n_status = ST_INVALID;
                end
            end
            MODE_CANCEL: begin
                if (rsv_hit) begin
                    n_rsv_valid = 1'b0;
                end else begin
                    n_status = ST_INVALID;
                end
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsv_valid <= 1'b0;
            r_rsv_slot  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_rsv_valid <= n_rsv_valid;
                r_rsv_slot  <= n_rsv_slot;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_status <= n_status;
            r_out_vvalid <= n_vvalid;
            r_out_vkey   <= n_vkey;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_vkey;
    assign o_m_tuser  = {r_out_vvalid, r_out_status};

    `LRUV_ASSERT_IMPL(a_rsv_resident, r_rsv_valid, slot_valid[r_rsv_slot])
    `LRUV_ASSERT_IMPL(a_count_matches, 1'b1, $countones(slot_valid) == r_count)
    `LRUV_ASSERT_NEXT(a_fire_gives_result, fire, o_m_tvalid)
    `LRUV_ASSERT_NEXT(a_victim_reserved, fire && n_vvalid, r_rsv_valid && o_m_tuser[3])

endmodule
